/* hw/rtl/bxf_pkg.sv */
// Shared widths, types and register indexes for the 3x3 box filter.
`default_nettype none

package bxf_pkg;

    localparam int MAX_WIDTH_DEF = 64;

    localparam int PIX_W        = 8;
    localparam int ROW_W        = 16;
    localparam int COL_OUT_W    = 6;
    localparam int IMG_WIDTH_W  = 7;
    localparam int IMG_HEIGHT_W = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    // A full window sums to at most 9 * 255, and at most nine cells count.
    localparam int SUM_W = 12;
    localparam int CNT_W = 4;

    localparam logic [IMG_WIDTH_W-1:0]  IMG_WIDTH_RST  = 7'd64;
    localparam logic [IMG_HEIGHT_W-1:0] IMG_HEIGHT_RST = 16'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [SUM_W-1:0] sum_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // One window column; element 0 is the oldest row, element 2 the current row.
    typedef pixel_t [2:0] bxf_col_t;

    // Which window rows and columns take part in one mean.
    typedef struct packed {
        logic [2:0] rows;
        logic [2:0] cols;
    } bxf_mask_t;

    // Position flags of one pixel, worked out when it enters.
    typedef struct packed {
        logic row_ge1;
        logic row_ge2;
        logic col_ge1;
        logic col_ge2;
        logic last_row;
        logic last_col;
    } bxf_flags_t;

endpackage

`default_nettype wire

/* hw/rtl/bxf_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module bxf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read and a write to the same address in one cycle return the old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hw/rtl/bxf_cell.sv */
// One window column cell; the cells form a chain that shifts left per pixel.
`default_nettype none

module bxf_cell
    import bxf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     shift,
    input  bxf_col_t col_in,
    output bxf_col_t col_out
);

    bxf_col_t col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (shift)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

`default_nettype wire

/* hw/rtl/bxf_sum.sv */
// Masked sum and cell count over the 3x3 window.
`default_nettype none

module bxf_sum
    import bxf_pkg::*;
(
    input  bxf_col_t  win0,
    input  bxf_col_t  win1,
    input  bxf_col_t  win2,
    input  bxf_mask_t mask,
    output sum_t      sum,
    output cnt_t      cnt
);

    bxf_col_t   win [3];
    logic [8:0] incl;

    assign win[0] = win0;
    assign win[1] = win1;
    assign win[2] = win2;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                incl[k*3+j] = mask.rows[k] & mask.cols[j];
            end
        end
    end

    always_comb
    begin
        sum = '0;
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (incl[k*3+j])
                begin
                    sum = sum + SUM_W'(win[j][k]);
                end
            end
        end
    end

    assign cnt = CNT_W'($countones(incl));

endmodule

`default_nettype wire

/* hw/rtl/bxf_div.sv */
// Floor division of a window sum by its cell count (1, 2, 3, 4, 6 or 9).
`default_nettype none

module bxf_div
    import bxf_pkg::*;
(
    input  sum_t   sum,
    input  cnt_t   cnt,
    output pixel_t quot
);

    // Reciprocals are exact over the sum ranges each count can produce.
    localparam int RECIP_W = 12;
    localparam int RECIP_3 = 2731;
    localparam int SHIFT_3 = 13;
    localparam int RECIP_9 = 3641;
    localparam int SHIFT_9 = 15;
    localparam int MUL_W   = SUM_W + RECIP_W;

    logic [SUM_W-1:0]   mul_a;
    logic [RECIP_W-1:0] mul_b;
    logic [MUL_W-1:0]   prod;
    logic [MUL_W-1:0]   quot_wide;

    always_comb
    begin
        mul_a = sum;
        mul_b = RECIP_W'(RECIP_3);
        case (cnt)
            4'd6:    mul_a = sum >> 1;
            4'd9:    mul_b = RECIP_W'(RECIP_9);
            default: ;
        endcase
    end

    assign prod = MUL_W'(mul_a) * MUL_W'(mul_b);

    always_comb
    begin
        case (cnt) inside
            4'd1:       quot_wide = MUL_W'(sum);
            4'd2:       quot_wide = MUL_W'(sum >> 1);
            4'd4:       quot_wide = MUL_W'(sum >> 2);
            4'd3, 4'd6: quot_wide = prod >> SHIFT_3;
            4'd9:       quot_wide = prod >> SHIFT_9;
            default:    quot_wide = '0;
        endcase
    end

    assign quot = quot_wide[PIX_W-1:0];

endmodule

`default_nettype wire

/* hw/rtl/box_filter_3x3_edge_avg_core.sv */
// Top level of the streaming 3x3 box filter with image-clipped mean.
// Path: line store read stage, result sequencing stage, divide stage, output register.
// Throughput: one pixel per cycle without output stall; a pixel that completes more
// than one result (up to 4, on the last row or column) holds the single result stage.
// Reset: counters and valids clear, width and height return to 64, window reads zero;
// line stores hold no defined data until written.
`default_nettype none

module box_filter_3x3_edge_avg_core
    import bxf_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIX_W-1:0]      pixel_in,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PIX_W-1:0]      smoothed,
    output logic [ROW_W-1:0]      out_row,
    output logic [COL_OUT_W-1:0]  out_col,
    output logic                  run_last,
    output logic                  frame_done,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LINE_W = 2 * PIX_W;

    // Configuration
    logic [IMG_WIDTH_W-1:0]  img_width_reg;
    logic [IMG_HEIGHT_W-1:0] img_height_reg;
    logic                    cfg_width_we;
    logic                    cfg_height_we;
    logic [CW-1:0]           w_last;
    logic [ROW_W-1:0]        h_last;

    // Input position
    logic [ROW_W-1:0]        row_reg;
    logic [CW-1:0]           col_reg;
    bxf_flags_t              cur_flags;

    // Line store read stage
    logic                    s1_valid_reg;
    pixel_t                  s1_px_reg;
    logic [ROW_W-1:0]        s1_row_reg;
    logic [CW-1:0]           s1_col_reg;
    bxf_flags_t              s1_flags_reg;
    logic                    byp_hit_reg;
    logic [LINE_W-1:0]       byp_data_reg;
    logic [LINE_W-1:0]       ram_rdata;
    logic [LINE_W-1:0]       line_q;
    logic [LINE_W-1:0]       line_wdata;
    bxf_col_t                new_col;

    // Window chain: chain[j] is window column j, chain[3] feeds the newest cell.
    bxf_col_t                chain [4];

    // Result sequencing stage
    logic [3:0]              pend_reg;
    logic [3:0]              pend_load;
    logic [3:0]              pend_sel;
    logic [3:0]              pend_rest;
    logic [ROW_W-1:0]        s2_row_reg;
    logic [CW-1:0]           s2_col_reg;
    bxf_flags_t              s2_flags_reg;
    logic                    sel_dr;
    logic                    sel_dc;
    bxf_mask_t               sel_mask;
    sum_t                    sel_sum;
    cnt_t                    sel_cnt;

    // Divide stage and output register
    logic                    s3_valid_reg;
    sum_t                    s3_sum_reg;
    cnt_t                    s3_cnt_reg;
    logic [ROW_W-1:0]        s3_row_reg;
    logic [CW-1:0]           s3_col_reg;
    logic                    s3_last_reg;
    logic                    s3_done_reg;
    logic [31:0]             s3_col_ext;
    pixel_t                  s3_quot;

    logic                    out_valid_reg;
    pixel_t                  out_pix_reg;
    logic [ROW_W-1:0]        out_row_reg;
    logic [COL_OUT_W-1:0]    out_col_reg;
    logic                    out_last_reg;
    logic                    out_done_reg;

    // Flow control
    logic                    out_ready;
    logic                    s3_ready;
    logic                    emit;
    logic                    s2_ready;
    logic                    s1_ready;
    logic                    s1_adv;
    logic                    accept;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_comb
    begin
        cfg_width_we  = 1'b0;
        cfg_height_we = 1'b0;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_width_we  = 1'b1;
                REG_IMAGE_HEIGHT: cfg_height_we = 1'b1;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_width_reg  <= IMG_WIDTH_RST;
            img_height_reg <= IMG_HEIGHT_RST;
        end
        else
        begin
            if (cfg_width_we)
            begin
                img_width_reg <= cfg_data[IMG_WIDTH_W-1:0];
            end
            if (cfg_height_we)
            begin
                img_height_reg <= cfg_data[IMG_HEIGHT_W-1:0];
            end
        end
    end

    // A width of zero acts as one, and a width beyond the line store is clamped.
    always_comb
    begin
        if (img_width_reg == '0)
        begin
            w_last = '0;
        end
        else if (32'(img_width_reg) > MAX_WIDTH)
        begin
            w_last = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last = CW'(img_width_reg - 7'd1);
        end
    end

    assign h_last = (img_height_reg == '0) ? '0 : img_height_reg - 16'd1;

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    assign out_ready = !out_valid_reg || !out_stall;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign emit      = (pend_reg != '0) && s3_ready;
    assign s2_ready  = (pend_reg == '0) || (emit && (pend_rest == '0));
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s1_adv    = s1_valid_reg && s2_ready;
    assign in_stall  = !s1_ready;
    assign accept    = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Input position counters
    // ------------------------------------------------------------------
    assign cur_flags.row_ge1  = (row_reg != '0);
    assign cur_flags.row_ge2  = (row_reg[ROW_W-1:1] != '0);
    assign cur_flags.col_ge1  = (col_reg != '0);
    assign cur_flags.col_ge2  = (32'(col_reg) >= 32'd2);
    assign cur_flags.last_row = (row_reg == h_last);
    assign cur_flags.last_col = (col_reg == w_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cfg_width_we || cfg_height_we)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            if (cur_flags.last_col)
            begin
                col_reg <= '0;
                row_reg <= cur_flags.last_row ? '0 : row_reg + 16'd1;
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Line stores: one RAM entry per column holds {two rows up, one row up}
    // ------------------------------------------------------------------
    bxf_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata (line_wdata),
        .re    (accept),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
            // With a one-pixel row the read meets the write of the previous pixel.
            byp_hit_reg  <= s1_valid_reg && (s1_col_reg == col_reg);
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg    <= pixel_in;
            s1_row_reg   <= row_reg;
            s1_col_reg   <= col_reg;
            s1_flags_reg <= cur_flags;
            byp_data_reg <= line_wdata;
        end
    end

    assign line_q     = byp_hit_reg ? byp_data_reg : ram_rdata;
    assign line_wdata = {line_q[PIX_W-1:0], s1_px_reg};

    // Rows not yet written in this frame enter the window as zero.
    assign new_col[0] = s1_flags_reg.row_ge2 ? line_q[LINE_W-1:PIX_W] : '0;
    assign new_col[1] = s1_flags_reg.row_ge1 ? line_q[PIX_W-1:0] : '0;
    assign new_col[2] = s1_px_reg;

    // ------------------------------------------------------------------
    // Window cell chain
    // ------------------------------------------------------------------
    assign chain[3] = new_col;

    for (genvar i = 0; i < 3; i++)
    begin : g_cell
        bxf_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .shift   (s1_adv),
            .col_in  (chain[i+1]),
            .col_out (chain[i])
        );
    end

    // ------------------------------------------------------------------
    // Result sequencing: bit 0 up-left, bit 1 up, bit 2 left, bit 3 the pixel itself
    // ------------------------------------------------------------------
    assign pend_load[0] = s1_flags_reg.row_ge1 & s1_flags_reg.col_ge1;
    assign pend_load[1] = s1_flags_reg.row_ge1 & s1_flags_reg.last_col;
    assign pend_load[2] = s1_flags_reg.last_row & s1_flags_reg.col_ge1;
    assign pend_load[3] = s1_flags_reg.last_row & s1_flags_reg.last_col;

    assign pend_sel  = pend_reg & (~pend_reg + 4'd1);
    assign pend_rest = pend_reg & ~pend_sel;
    assign sel_dr    = pend_sel[2] | pend_sel[3];
    assign sel_dc    = pend_sel[1] | pend_sel[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (s1_adv)
        begin
            pend_reg <= pend_load;
        end
        else if (emit)
        begin
            pend_reg <= pend_rest;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_row_reg   <= s1_row_reg;
            s2_col_reg   <= s1_col_reg;
            s2_flags_reg <= s1_flags_reg;
        end
    end

    // A result on the current row or column drops the oldest window row or column.
    assign sel_mask.rows = {1'b1, s2_flags_reg.row_ge1, !sel_dr && s2_flags_reg.row_ge2};
    assign sel_mask.cols = {1'b1, s2_flags_reg.col_ge1, !sel_dc && s2_flags_reg.col_ge2};

    bxf_sum u_sum (
        .win0 (chain[0]),
        .win1 (chain[1]),
        .win2 (chain[2]),
        .mask (sel_mask),
        .sum  (sel_sum),
        .cnt  (sel_cnt)
    );

    // ------------------------------------------------------------------
    // Divide stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            s3_sum_reg  <= sel_sum;
            s3_cnt_reg  <= sel_cnt;
            s3_row_reg  <= s2_row_reg + ROW_W'(sel_dr) - 16'd1;
            s3_col_reg  <= s2_col_reg + CW'(sel_dc) - CW'(1);
            s3_last_reg <= (pend_rest == '0);
            s3_done_reg <= pend_sel[3];
        end
    end

    bxf_div u_div (
        .sum  (s3_sum_reg),
        .cnt  (s3_cnt_reg),
        .quot (s3_quot)
    );

    assign s3_col_ext = 32'(s3_col_reg);

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s3_valid_reg)
        begin
            out_pix_reg  <= s3_quot;
            out_row_reg  <= s3_row_reg;
            out_col_reg  <= s3_col_ext[COL_OUT_W-1:0];
            out_last_reg <= s3_last_reg;
            out_done_reg <= s3_done_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign smoothed   = out_pix_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign run_last   = out_last_reg;
    assign frame_done = out_done_reg;

endmodule

`default_nettype wire

/* hw/rtl/bxf_checker.sv */
// Port-level assertions for the 3x3 box filter, bound to its top level.
`default_nettype none

module bxf_checker
    import bxf_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire logic [PIX_W-1:0]     smoothed,
    input wire logic [ROW_W-1:0]     out_row,
    input wire logic [COL_OUT_W-1:0] out_col,
    input wire logic                 run_last,
    input wire logic                 frame_done
);

    // A stalled result transaction keeps its valid and its payload.
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(smoothed) && $stable(out_row)
            && $stable(out_col) && $stable(run_last) && $stable(frame_done)
    ) else $error("stalled result changed or dropped");

    // The bottom-right pixel is always the final result of its input pixel.
    a_done_is_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> run_last
    ) else $error("frame end without run end");

    // Nothing is presented straight out of reset.
    a_reset_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid
    ) else $error("result valid right after reset");

endmodule

bind box_filter_3x3_edge_avg_core bxf_checker u_bxf_checker (.*);

`default_nettype wire

/* sim/box_filter_3x3_edge_avg_core_test.sv */
// Self-checking testbench for the streaming 3x3 clipped-mean box filter core.
`timescale 1ns / 100ps

module box_filter_3x3_edge_avg_core_test;
    import bxf_pkg::*;

    localparam int LINE_DEPTH    = MAX_WIDTH_DEF;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 184;
    localparam int REPORT_LIMIT  = 10;

    // Register indexes with no register behind them.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_mode_t;

    typedef struct packed {
        pixel_t                mean;
        logic [ROW_W-1:0]      row;
        logic [COL_OUT_W-1:0]  col;
        logic                  run_end;
        logic                  frame_end;
    } mean_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    pixel_t                pixel_in;
    logic                  out_valid;
    logic                  out_stall;
    pixel_t                smoothed;
    logic [ROW_W-1:0]      out_row;
    logic [COL_OUT_W-1:0]  out_col;
    logic                  run_last;
    logic                  frame_done;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Filter state as the predictor tracks it.
    pixel_t                  older_row [LINE_DEPTH];
    pixel_t                  prior_row [LINE_DEPTH];
    pixel_t                  win [9];
    int unsigned             next_row;
    int unsigned             next_col;
    logic [IMG_WIDTH_W-1:0]  width_reg;
    logic [IMG_HEIGHT_W-1:0] height_reg;
    mean_result_t            pending_means [$];

    mean_result_t got;
    mean_result_t want;
    int fail_count    = 0;
    int items_sent    = 0;
    int random_start  = 0;
    int hold_requests = 0;
    int cycle_count   = 0;
    int burst_left    = 1;

    box_filter_3x3_edge_avg_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel_in   (pixel_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .smoothed   (smoothed),
        .out_row    (out_row),
        .out_col    (out_col),
        .run_last   (run_last),
        .frame_done (frame_done),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void init_filter_model();
        for (int i = 0; i < LINE_DEPTH; i++)
        begin
            older_row[i] = '0;
            prior_row[i] = '0;
        end
        for (int i = 0; i < 9; i++)
            win[i] = '0;
        next_row   = 0;
        next_col   = 0;
        width_reg  = IMG_WIDTH_RST;
        height_reg = IMG_HEIGHT_RST;
    endfunction

    function automatic int unsigned active_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > LINE_DEPTH)
            return LINE_DEPTH;
        return width_reg;
    endfunction

    function automatic int unsigned active_height();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    // Any write to a real register starts a new frame; the line stores keep their data.
    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] val);
        if (idx == REG_IMAGE_WIDTH)
            width_reg = val[IMG_WIDTH_W-1:0];
        else if (idx == REG_IMAGE_HEIGHT)
            height_reg = val;
        else
            return;
        next_row = 0;
        next_col = 0;
    endfunction

    // Window cell (k,j) holds the pixel at row r-2+k, column c-2+j; only cells inside
    // both the image and the neighborhood of (cr,cc) take part.
    function automatic pixel_t clipped_mean(int r, int c, int cr, int cc);
        int unsigned sum;
        int unsigned cnt;
        int wr;
        int wc;
        sum = 0;
        cnt = 0;
        for (int k = 0; k < 3; k++)
        begin
            wr = r - 2 + k;
            if (wr < 0 || wr < cr - 1 || wr > cr + 1)
                continue;
            for (int j = 0; j < 3; j++)
            begin
                wc = c - 2 + j;
                if (wc < 0 || wc < cc - 1 || wc > cc + 1)
                    continue;
                sum += win[k * 3 + j];
                cnt++;
            end
        end
        return (cnt == 0) ? pixel_t'(0) : pixel_t'(sum / cnt);
    endfunction

    function automatic void filter_pixel(pixel_t px);
        int unsigned w;
        int unsigned h;
        int unsigned ur;
        int unsigned uc;
        int cr;
        int cc;
        int n;
        mean_result_t res;
        w = active_width();
        h = active_height();
        if (next_col >= w || next_row >= h)
        begin
            next_row = 0;
            next_col = 0;
        end
        ur = next_row;
        uc = next_col;

        for (int k = 0; k < 3; k++)
        begin
            win[k * 3]     = win[k * 3 + 1];
            win[k * 3 + 1] = win[k * 3 + 2];
        end
        win[2] = (ur >= 2) ? older_row[uc] : pixel_t'(0);
        win[5] = (ur >= 1) ? prior_row[uc] : pixel_t'(0);
        win[8] = px;
        older_row[uc] = prior_row[uc];
        prior_row[uc] = px;

        n = 0;
        for (int dr = 0; dr < 2; dr++)
        begin
            if (dr == 0 && ur < 1)
                continue;
            if (dr == 1 && ur != h - 1)
                continue;
            for (int dc = 0; dc < 2; dc++)
            begin
                if (dc == 0 && uc < 1)
                    continue;
                if (dc == 1 && uc != w - 1)
                    continue;
                cr = int'(ur) - 1 + dr;
                cc = int'(uc) - 1 + dc;
                res.mean      = clipped_mean(int'(ur), int'(uc), cr, cc);
                res.row       = ROW_W'(cr);
                res.col       = COL_OUT_W'(cc);
                res.run_end   = 1'b0;
                res.frame_end = (cr == h - 1 && cc == w - 1);
                pending_means.push_back(res);
                n++;
            end
        end
        if (n > 0)
            pending_means[pending_means.size() - 1].run_end = 1'b1;

        if (uc + 1 >= w)
        begin
            next_col = 0;
            next_row = (ur + 1 >= h) ? 0 : ur + 1;
        end
        else
            next_col = uc + 1;
    endfunction

    function automatic pixel_t random_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return pixel_t'($urandom_range(0, 255));
        endcase
    endfunction

    // Offers one pixel until the transaction completes, then paces the next burst.
    task automatic send_pixel(input pixel_t px);
        int gap;
        in_valid <= 1'b1;
        pixel_in <= px;
        do
            @(posedge clk);
        while (in_stall);
        filter_pixel(px);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_random(input int count);
        repeat (count) send_pixel(random_pixel());
    endtask

    // Pixels that complete no result may still be in flight, hence the settle time.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_means.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        apply_register(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] wd,
                             input logic [CFG_DATA_W-1:0] hd);
        write_reg(REG_IMAGE_WIDTH, wd);
        write_reg(REG_IMAGE_HEIGHT, hd);
    endtask

    // Zero sizes act as one: single-pixel frames, then one-column and one-row images.
    task automatic test_thin_frames();
        set_frame(0, 0);
        send_pixel('1);
        send_pixel('0);
        wait_idle();
        set_frame(1, 3);
        send_pixel('0);
        send_pixel('1);
        send_pixel('1);
        wait_idle();
        set_frame(3, 1);
        send_pixel('1);
        send_pixel('1);
        send_pixel('0);
        wait_idle();
    endtask

    task automatic test_full_window();
        set_frame(3, 3);
        repeat (9) send_pixel('1);
        wait_idle();
    endtask

    // An oversized width acts as the maximum; a write mid-row restarts the frame,
    // while a write to a spare index leaves the position alone.
    task automatic test_restart_and_spare();
        set_frame(127, 16'hFFFF);
        send_random(3);
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, 2);
        write_reg(REG_IMAGE_WIDTH, 3);
        send_pixel('1);
        send_pixel('0);
        wait_idle();
        write_reg(REG_SPARE_2, '1);
        write_reg(REG_SPARE_3, '1);
        send_pixel('1);
        send_pixel('0);
        send_pixel('1);
        send_pixel('0);
        wait_idle();
    endtask

    // The receiver holds off for a long time while a full-width row streams in.
    task automatic test_wide_row_backpressure();
        set_frame(64, 1);
        hold_requests++;
        send_random(64);
        wait_idle();
    endtask

    task automatic test_tall_frame();
        set_frame(2, 16'hFFFF);
        send_random(40);
        wait_idle();
    endtask

    task automatic test_random_frames();
        logic [CFG_DATA_W-1:0] wd;
        logic [CFG_DATA_W-1:0] hd;
        int unsigned frame;
        int unsigned count;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       wd = '0;
                1:       wd = CFG_DATA_W'($urandom_range(65, 127));
                2:       wd = CFG_DATA_W'(64);
                default: wd = CFG_DATA_W'($urandom_range(1, 8));
            endcase
            // Bits above the width register are don't-care.
            if ($urandom_range(0, 1) == 1)
                wd[CFG_DATA_W-1:IMG_WIDTH_W] = 9'($urandom_range(0, 511));
            hd = ($urandom_range(0, 9) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 6));
            case ($urandom_range(0, 3))
                0:       write_reg(REG_IMAGE_WIDTH, wd);
                1:       write_reg(REG_IMAGE_HEIGHT, hd);
                default: set_frame(wd, hd);
            endcase
            frame = active_width() * active_height();
            if (frame <= 48)
                count = frame * $urandom_range(1, 2) +
                        (($urandom_range(0, 1) == 1) ? $urandom_range(0, frame - 1) : 0);
            else
                count = $urandom_range(20, 60);
            if (count > RANDOM_ITEMS - (items_sent - random_start))
                count = RANDOM_ITEMS - (items_sent - random_start);
            if ($urandom_range(0, 4) == 0)
                hold_requests++;
            send_random(count);
            wait_idle();
        end
    endtask

    initial
    begin : receiver_pattern
        stall_mode_t mode;
        int mode_left;
        int hold_left;
        int holds_seen;
        mode       = STALL_NONE;
        mode_left  = 0;
        hold_left  = 0;
        holds_seen = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_seen != hold_requests)
            begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = stall_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:     out_stall <= ~out_stall;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got = {smoothed, out_row, out_col, run_last, frame_done};
            if (pending_means.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected: mean %0d row %0d col %0d last %0b done %0b",
                             got.mean, got.row, got.col, got.run_end, got.frame_end);
            end
            else
            begin
                want = pending_means.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("mismatch: expected mean %0d row %0d col %0d last %0b done %0b",
                                 want.mean, want.row, want.col, want.run_end, want.frame_end);
                        $display("          actual   mean %0d row %0d col %0d last %0b done %0b",
                                 got.mean, got.row, got.col, got.run_end, got.frame_end);
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        pixel_in  = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        init_filter_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_thin_frames();
        test_full_window();
        test_restart_and_spare();
        random_start = items_sent;
        test_wide_row_backpressure();
        test_tall_frame();
        test_random_frames();

        wait_idle();
        fail_count += pending_means.size();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/bxf_pkg.sv
hw/rtl/bxf_ram.sv
hw/rtl/bxf_cell.sv
hw/rtl/bxf_sum.sv
hw/rtl/bxf_div.sv
hw/rtl/box_filter_3x3_edge_avg_core.sv
hw/rtl/bxf_checker.sv
sim/box_filter_3x3_edge_avg_core_test.sv
